// File: rtl/addressable_led_spi_encoder_defines.svh
// Assertion macros for the addressable LED SPI encoder checker.
// No dependencies; included by the checker file only.
`ifndef ADDRESSABLE_LED_SPI_ENCODER_DEFINES_SVH
`define ADDRESSABLE_LED_SPI_ENCODER_DEFINES_SVH

// Checked only while out of reset.
`define ALSE_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ALSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/alse_pkg.sv
// Types and constants shared by the addressable LED SPI encoder.
// No dependencies.
package alse_pkg;

    localparam logic [5:0] CODE_ZERO   = 6'b110000;
    localparam logic [5:0] CODE_ONE    = 6'b111000;
    localparam logic [5:0] GAP_RESET   = 6'd40;
    localparam logic [5:0] GAP_MAX     = 6'd46;
    localparam logic [2:0] LAST_SUB    = 3'd5;
    localparam logic [1:0] LAST_COLOUR = 2'd2;
    localparam logic [7:0] GAP_BYTE    = 8'h00;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_gap;
        logic       run_end;
    } spi_word_t;

    // one queued pixel, already classified
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic [5:0] gap_len;
        logic       invert;
    } job_t;

    // byte idx (0..5) of the 48-bit code stream of one colour
    function automatic logic [7:0] encode_byte(input logic [7:0] c, input logic [2:0] idx);
        logic [47:0] acc;
        logic [7:0]  res;
        for (int i = 0; i < 8; i++) begin
            acc[47 - 6*i -: 6] = c[7 - i] ? CODE_ONE : CODE_ZERO;
        end
        case (idx)
            3'd0:    res = acc[47:40];
            3'd1:    res = acc[39:32];
            3'd2:    res = acc[31:24];
            3'd3:    res = acc[23:16];
            3'd4:    res = acc[15:8];
            3'd5:    res = acc[7:0];
            default: res = acc[47:40];
        endcase
        return res;
    endfunction

endpackage

// File: rtl/alse_fifo.sv
// Small register queue between the front and back parts of the encoder.
// Depends on alse_pkg for job_t.
module alse_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  alse_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output alse_pkg::job_t pop_data
);
    import alse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/alse_front.sv
// Front part: configuration registers, pixel acceptance and classification.
// Depends on alse_pkg.
module alse_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [alse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  alse_pkg::pixel_t                s_pixel,
    input  logic                            q_full,
    output logic                            q_push,
    output alse_pkg::job_t                  q_job
);
    import alse_pkg::*;

    logic       invert_reg;
    logic [5:0] gap_reg;
    logic [5:0] gap_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
            gap_reg    <= GAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INVERT: invert_reg <= cfg_wdata[0];
                REG_GAP:    gap_reg    <= cfg_wdata[5:0];
                default:    ;
            endcase
        end
    end

    assign gap_sat = (gap_reg > GAP_MAX) ? GAP_MAX : gap_reg;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_job.green   = s_pixel.green;
        q_job.red     = s_pixel.red;
        q_job.blue    = s_pixel.blue;
        q_job.gap_len = s_pixel.last_pixel ? gap_sat : 6'd0;
        q_job.invert  = invert_reg;
    end

endmodule

// File: rtl/alse_back.sv
// Back part: walks one queued pixel byte by byte into the output register.
// Depends on alse_pkg.
module alse_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  alse_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output alse_pkg::spi_word_t m_word
);
    import alse_pkg::*;

    logic       busy_reg, busy_next;
    job_t       job_reg, job_next;
    logic [1:0] col_reg, col_next;
    logic [2:0] sub_reg, sub_next;
    logic       in_gap_reg, in_gap_next;
    logic [5:0] gap_left_reg, gap_left_next;
    logic       out_valid_reg, out_valid_next;
    spi_word_t  out_reg, out_next;

    logic       advance;
    spi_word_t  cur;
    logic [7:0] colour;
    logic [7:0] inv_mask;

    assign inv_mask = {8{job_reg.invert}};

    always_comb begin
        case (col_reg)
            2'd0:    colour = job_reg.green;
            2'd1:    colour = job_reg.red;
            default: colour = job_reg.blue;
        endcase
        if (in_gap_reg) begin
            cur.spi_byte = GAP_BYTE ^ inv_mask;
            cur.is_gap   = 1'b1;
            cur.run_end  = (gap_left_reg == 6'd1);
        end else begin
            cur.spi_byte = encode_byte(colour, sub_reg) ^ inv_mask;
            cur.is_gap   = 1'b0;
            cur.run_end  = (col_reg == LAST_COLOUR) && (sub_reg == LAST_SUB)
                           && (job_reg.gap_len == 6'd0);
        end
    end

    assign advance = busy_reg && (!out_valid_reg || m_ready);
    assign q_pop   = q_not_empty && (!busy_reg || (advance && cur.run_end));

    always_comb begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        col_next       = col_reg;
        sub_next       = sub_reg;
        in_gap_next    = in_gap_reg;
        gap_left_next  = gap_left_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        if (advance) begin
            out_valid_next = 1'b1;
            out_next       = cur;
            if (cur.run_end) begin
                busy_next = 1'b0;
            end else if (in_gap_reg) begin
                gap_left_next = gap_left_reg - 1'b1;
            end else if (sub_reg == LAST_SUB) begin
                sub_next = 3'd0;
                if (col_reg == LAST_COLOUR) begin
                    in_gap_next = 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end else begin
                sub_next = sub_reg + 1'b1;
            end
        end

        if (q_pop) begin
            busy_next     = 1'b1;
            job_next      = q_job;
            col_next      = 2'd0;
            sub_next      = 3'd0;
            in_gap_next   = 1'b0;
            gap_left_next = q_job.gap_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        col_reg      <= col_next;
        sub_reg      <= sub_next;
        in_gap_reg   <= in_gap_next;
        gap_left_reg <= gap_left_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

// File: rtl/addressable_led_spi_encoder.sv
// Channel   Dir  Payload                        Handshake
// s_        in   pixel_t (r, g, b, last_pixel)  s_valid / s_ready
// m_        out  spi_word_t (byte, gap, end)    m_valid / m_ready
// cfg_      in   index + 6-bit data             cfg_we, no wait
//
// Each pixel gives 18 bytes, plus the gap length when it is the last pixel;
// the back sequencer emits one byte per cycle while the output is not stalled,
// and the next pixel follows without a bubble when the queue holds one.
// Reset (aresetn, synchronous) empties the queue and output register.
// m_ready low holds the output byte; the queue keeps taking pixels until full.
// Top level of the addressable LED SPI encoder; depends on alse_pkg,
// alse_front, alse_fifo and alse_back.
module addressable_led_spi_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [alse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  alse_pkg::pixel_t                s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output alse_pkg::spi_word_t             m_word
);
    import alse_pkg::*;

    logic q_push, q_full, q_pop, q_not_empty;
    job_t push_job, pop_job;

    alse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    alse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_job)
    );

    alse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

endmodule

// File: rtl/alse_checker.sv
// Port-level checks on the addressable LED SPI encoder, bound to the top.
// Depends on alse_pkg and addressable_led_spi_encoder_defines.svh.
`include "addressable_led_spi_encoder_defines.svh"

module alse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input alse_pkg::spi_word_t m_word
);
    import alse_pkg::*;

    `ALSE_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "output valid after reset")
    `ALSE_ASSERT_RUN(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_word), "stalled word changed")
    `ALSE_ASSERT_RUN(a_gap_level, m_valid && m_word.is_gap |-> m_word.spi_byte == 8'h00 || m_word.spi_byte == 8'hFF, "gap word not flat")

endmodule

bind addressable_led_spi_encoder alse_checker u_alse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
